// ===== src/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared constants and types for the least-squares slope block
// Coordinate and result widths, parameter defaults and the back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  // Coordinate width on the input ports
  localparam int unsigned CoordBits = 16;

  // Result width (signed Q31.16 by default)
  localparam int unsigned ResultW = 48;

  // Parameter defaults
  localparam int unsigned MaxPointsDef    = 256;
  localparam int unsigned FractionBitsDef = 16;

  // Number of closed sets buffered between front and back
  localparam int unsigned SetQueueDepth = 2;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BkIdle,
    BkSub,
    BkPrep,
    BkDiv,
    BkFin
  } bk_state_e;

endpackage

`default_nettype wire

// ===== src/lss_front.sv =====
// ----------------------------------------------------------------------------
// lss_front: point intake and accumulation
// Registers each point with its square and cross product, then folds it into the running
// count and sums; a last point hands the closed set to the set queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_front #(
  parameter int unsigned MAX_POINTS = lss_pkg::MaxPointsDef,
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1),
  localparam int unsigned SumW = lss_pkg::CoordBits + CntW,
  localparam int unsigned SxxW = 2 * lss_pkg::CoordBits - 1 + CntW,
  localparam int unsigned SxyW = 2 * lss_pkg::CoordBits + CntW
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // point channel
  input  logic                                  push_i,
  input  logic signed [lss_pkg::CoordBits-1:0]  x_value_i,
  input  logic signed [lss_pkg::CoordBits-1:0]  y_value_i,
  input  logic                                  last_point_i,
  output logic                                  full_o,
  // closed-set channel
  input  logic                                  snap_full_i,
  output logic                                  snap_push_o,
  output logic        [CntW-1:0]                snap_count_o,
  output logic signed [SumW-1:0]                snap_sx_o,
  output logic signed [SumW-1:0]                snap_sy_o,
  output logic        [SxxW-1:0]                snap_sxx_o,
  output logic signed [SxyW-1:0]                snap_sxy_o,
  output logic                                  snap_ovf_o
);

  localparam int unsigned Cb   = lss_pkg::CoordBits;
  localparam int unsigned SqW  = 2 * Cb - 1;
  localparam int unsigned PrW  = 2 * Cb;

  logic                 a_valid_q, a_valid_d;
  logic                 a_last_q;
  logic signed [Cb-1:0] a_x_q, a_y_q;
  logic [SqW-1:0]       a_xx_q;
  logic signed [PrW-1:0] a_xy_q;

  logic [CntW-1:0]        cnt_q, cnt_d, cnt_n;
  logic signed [SumW-1:0] sx_q, sx_d, sx_n, sy_q, sy_d, sy_n;
  logic [SxxW-1:0]        sxx_q, sxx_d, sxx_n;
  logic signed [SxyW-1:0] sxy_q, sxy_d, sxy_n;
  logic                   ovf_q, ovf_d, ovf_n;

  logic                   accept, advance, in_range;
  logic signed [PrW-1:0]  xx_full, xy_full;

  // Square and cross product of the incoming point
  assign xx_full = PrW'(x_value_i) * PrW'(x_value_i);
  assign xy_full = PrW'(x_value_i) * PrW'(y_value_i);

  // Hold a last point while the set queue has no room
  assign advance = a_valid_q && !(a_last_q && snap_full_i);
  assign full_o  = a_valid_q && a_last_q && snap_full_i;
  assign accept  = push_i && !full_o;

  assign a_valid_d = accept ? 1'b1 : (advance ? 1'b0 : a_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  // Capture the point beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_x_q    <= x_value_i;
      a_y_q    <= y_value_i;
      a_xx_q   <= xx_full[SqW-1:0];
      a_xy_q   <= xy_full;
      a_last_q <= last_point_i;
    end
  end

  // Fold the point in, or drop it once the set is full
  always_comb begin
    in_range = cnt_q < CntW'(MAX_POINTS);
    cnt_n    = cnt_q;
    sx_n     = sx_q;
    sy_n     = sy_q;
    sxx_n    = sxx_q;
    sxy_n    = sxy_q;
    ovf_n    = ovf_q;
    if (in_range) begin
      cnt_n = cnt_q + CntW'(1);
      sx_n  = sx_q + SumW'(a_x_q);
      sy_n  = sy_q + SumW'(a_y_q);
      sxx_n = sxx_q + SxxW'(a_xx_q);
      sxy_n = sxy_q + SxyW'(a_xy_q);
    end else begin
      ovf_n = 1'b1;
    end
  end

  // Fold in each advancing point, or clear the sums after a closed set
  always_comb begin
    cnt_d = cnt_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sxx_d = sxx_q;
    sxy_d = sxy_q;
    ovf_d = ovf_q;
    if (advance) begin
      if (a_last_q) begin
        cnt_d = '0;
        sx_d  = '0;
        sy_d  = '0;
        sxx_d = '0;
        sxy_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_n;
        sx_d  = sx_n;
        sy_d  = sy_n;
        sxx_d = sxx_n;
        sxy_d = sxy_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sxx_q <= sxx_d;
      sxy_q <= sxy_d;
      ovf_q <= ovf_d;
    end
  end

  // Hand the closed set on
  assign snap_push_o  = advance && a_last_q;
  assign snap_count_o = cnt_n;
  assign snap_sx_o    = sx_n;
  assign snap_sy_o    = sy_n;
  assign snap_sxx_o   = sxx_n;
  assign snap_sxy_o   = sxy_n;
  assign snap_ovf_o   = ovf_n;

endmodule

`default_nettype wire

// ===== src/lss_fifo.sv =====
// ----------------------------------------------------------------------------
// lss_fifo: short set queue
// Buffers closed sets between the accumulating front and the dividing back.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lss_pkg::SetQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rd_ptr_q];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Fill level never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("set queue fill level beyond depth");

endmodule

`default_nettype wire

// ===== src/lss_back.sv =====
// ----------------------------------------------------------------------------
// lss_back: determinant, numerator and slope division
// Takes one closed set at a time, forms det and num from registered
// products, divides one quotient bit per cycle and saturates the slope.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_back #(
  parameter int unsigned MAX_POINTS    = lss_pkg::MaxPointsDef,
  parameter int unsigned FRACTION_BITS = lss_pkg::FractionBitsDef,
  localparam int unsigned CntW = $clog2(MAX_POINTS + 1),
  localparam int unsigned SumW = lss_pkg::CoordBits + CntW,
  localparam int unsigned SxxW = 2 * lss_pkg::CoordBits - 1 + CntW,
  localparam int unsigned SxyW = 2 * lss_pkg::CoordBits + CntW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // closed-set channel
  input  logic                                snap_empty_i,
  output logic                                snap_pop_o,
  input  logic        [CntW-1:0]              snap_count_i,
  input  logic signed [SumW-1:0]              snap_sx_i,
  input  logic signed [SumW-1:0]              snap_sy_i,
  input  logic        [SxxW-1:0]              snap_sxx_i,
  input  logic signed [SxyW-1:0]              snap_sxy_i,
  input  logic                                snap_ovf_i,
  // result channel
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic signed [lss_pkg::ResultW-1:0]  slope_o,
  output logic                                no_slope_o,
  output logic                                overflowed_o
);

  localparam int unsigned Cb    = lss_pkg::CoordBits;
  localparam int unsigned Rw    = lss_pkg::ResultW;
  localparam int unsigned PaW   = CntW + SxxW;
  localparam int unsigned PbW   = 2 * SumW;
  localparam int unsigned PcW   = CntW + 1 + SxyW;
  localparam int unsigned WideW = 2 * Cb + 2 * CntW + 2;
  localparam int unsigned DetW  = 2 * Cb - 1 + 2 * CntW;
  localparam int unsigned NumW  = 2 * Cb + 2 * CntW + 1;
  localparam int unsigned MagW  = NumW - 1;
  localparam int unsigned DivW  = MagW + FRACTION_BITS;
  localparam int unsigned StepW = $clog2(DivW);
  localparam int unsigned QxW   = (DivW > Rw) ? DivW : Rw;

  lss_pkg::bk_state_e state_q, state_d;

  logic [PaW-1:0]          pa_q;
  logic signed [PbW-1:0]   pb_q, pd_q;
  logic signed [PcW-1:0]   pc_q;
  logic [DetW-1:0]         det_q, rem_q;
  logic signed [NumW-1:0]  num_q;
  logic [DivW-1:0]         dvd_q;
  logic [StepW-1:0]        step_q;
  logic                    neg_q, nos_q, ovf_q;

  logic                    res_valid_q, res_valid_d;
  logic signed [Rw-1:0]    res_slope_q;
  logic                    res_nos_q, res_ovf_q;

  logic                    out_free, load_res, det_zero;
  logic signed [WideW-1:0] wa, wb, wc, wd;
  logic signed [NumW-1:0]  mag_full;
  logic [DetW+1:0]         trial;
  logic                    trial_ge;
  logic [QxW-1:0]          quot, pos_max, neg_lim, q_sat;
  logic [Rw-1:0]           slope_n;

  assign out_free   = !res_valid_q || pop_i;
  assign det_zero   = det_q == '0;
  assign snap_pop_o = (state_q == lss_pkg::BkIdle) && !snap_empty_i;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    load_res = 1'b0;
    unique case (state_q)
      lss_pkg::BkIdle: begin
        if (!snap_empty_i) begin
          state_d = lss_pkg::BkSub;
        end
      end
      lss_pkg::BkSub: begin
        state_d = lss_pkg::BkPrep;
      end
      lss_pkg::BkPrep: begin
        state_d = det_zero ? lss_pkg::BkFin : lss_pkg::BkDiv;
      end
      lss_pkg::BkDiv: begin
        if (step_q == '0) begin
          state_d = lss_pkg::BkFin;
        end
      end
      lss_pkg::BkFin: begin
        if (out_free) begin
          load_res = 1'b1;
          state_d  = lss_pkg::BkIdle;
        end
      end
      default: begin
        state_d = lss_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Wide differences for det and num
  assign wa = signed'(WideW'(pa_q));
  assign wb = WideW'(pb_q);
  assign wc = WideW'(pc_q);
  assign wd = WideW'(pd_q);

  // Magnitude of the numerator
  assign mag_full = num_q[NumW-1] ? -num_q : num_q;

  // One restoring division step
  assign trial    = {1'b0, rem_q, dvd_q[DivW-1]} - {2'b00, det_q};
  assign trial_ge = !trial[DetW+1];

  // Saturate and apply the sign
  assign quot    = QxW'(dvd_q);
  assign pos_max = QxW'({(Rw - 1){1'b1}});
  assign neg_lim = QxW'(1) << (Rw - 1);

  always_comb begin
    if (neg_q) begin
      q_sat   = (quot > neg_lim) ? neg_lim : quot;
      slope_n = -q_sat[Rw-1:0];
    end else begin
      q_sat   = (quot > pos_max) ? pos_max : quot;
      slope_n = q_sat[Rw-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == lss_pkg::BkPrep) begin
      step_q <= StepW'(DivW - 1);
    end else if (state_q == lss_pkg::BkDiv) begin
      step_q <= step_q - StepW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      lss_pkg::BkIdle: begin
        pa_q  <= PaW'(snap_count_i) * PaW'(snap_sxx_i);
        pb_q  <= PbW'(snap_sx_i) * PbW'(snap_sx_i);
        pc_q  <= PcW'(signed'({1'b0, snap_count_i})) * PcW'(snap_sxy_i);
        pd_q  <= PbW'(snap_sx_i) * PbW'(snap_sy_i);
        ovf_q <= snap_ovf_i;
      end
      lss_pkg::BkSub: begin
        det_q <= DetW'(wa - wb);
        num_q <= NumW'(wc - wd);
      end
      lss_pkg::BkPrep: begin
        neg_q <= num_q[NumW-1];
        nos_q <= det_zero;
        dvd_q <= DivW'(mag_full[MagW-1:0]) << FRACTION_BITS;
        rem_q <= '0;
      end
      lss_pkg::BkDiv: begin
        rem_q <= trial_ge ? trial[DetW-1:0] : {rem_q[DetW-2:0], dvd_q[DivW-1]};
        dvd_q <= {dvd_q[DivW-2:0], trial_ge};
      end
      default: begin
      end
    endcase
  end

  // Result register
  assign res_valid_d = load_res ? 1'b1 : ((pop_i && res_valid_q) ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_slope_q <= nos_q ? '0 : signed'(slope_n);
      res_nos_q   <= nos_q;
      res_ovf_q   <= ovf_q;
    end
  end

  assign empty_o      = !res_valid_q;
  assign slope_o      = res_slope_q;
  assign no_slope_o   = res_nos_q;
  assign overflowed_o = res_ovf_q;

  // Never divide by a zero determinant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lss_pkg::BkDiv |-> det_q != '0)
    else $error("division started on zero determinant");

  // A finished set lands in the result register on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lss_pkg::BkFin && out_free |=> res_valid_q && state_q == lss_pkg::BkIdle)
    else $error("finished slope not delivered");

  // A missing slope reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_nos_q |-> res_slope_q == '0)
    else $error("no_slope result carries a slope");

endmodule

`default_nettype wire

// ===== src/least_squares_slope.sv =====
// ----------------------------------------------------------------------------
// least_squares_slope: least-squares slope of a set of signed points
// Accumulates points and emits num/det as signed fixed point with FRACTION_BITS fraction bits (Q31.16 at the defaults).
// ----------------------------------------------------------------------------
// Usage:
//   Points enter through a queue-style port: a beat is taken on a rising edge
//   with push high and full low. last_point closes the set. Only points up to
//   MAX_POINTS count; later ones are dropped and the result shows overflowed.
//   Results leave through a queue-style port: the result is on the ports while
//   empty is low and is taken on an edge with pop high.
//   Throughput: one point per cycle while full is low. The divider forms
//   DIV = 2*CoordBits + 2*clog2(MAX_POINTS+1) + FRACTION_BITS quotient bits
//   (66 at the defaults), one quotient bit a cycle; two closed sets wait in
//   the set queue, beyond that a last point holds full high.
//   A stalled receiver holds the result register and the back end waits with
//   its finished set; the point intake carries on until the set queue fills.
//   Reset clears the sums, the set queue and the result register at once.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_slope #(
  parameter int unsigned MAX_POINTS    = lss_pkg::MaxPointsDef,
  parameter int unsigned FRACTION_BITS = lss_pkg::FractionBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [lss_pkg::CoordBits-1:0]  x_value_i,
  input  logic signed [lss_pkg::CoordBits-1:0]  y_value_i,
  input  logic                                  last_point_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [lss_pkg::ResultW-1:0]    slope_o,
  output logic                                  no_slope_o,
  output logic                                  overflowed_o
);

  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SumW  = lss_pkg::CoordBits + CntW;
  localparam int unsigned SxxW  = 2 * lss_pkg::CoordBits - 1 + CntW;
  localparam int unsigned SxyW  = 2 * lss_pkg::CoordBits + CntW;
  localparam int unsigned SnapW = CntW + 2 * SumW + SxxW + SxyW + 1;

  logic                   snap_push, snap_full, snap_pop, snap_empty;
  logic [SnapW-1:0]       snap_wdata, snap_rdata;
  logic [CntW-1:0]        f_count, b_count;
  logic signed [SumW-1:0] f_sx, f_sy, b_sx, b_sy;
  logic [SxxW-1:0]        f_sxx, b_sxx;
  logic signed [SxyW-1:0] f_sxy, b_sxy;
  logic                   f_ovf, b_ovf;

  lss_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .last_point_i (last_point_i),
    .full_o       (full),
    .snap_full_i  (snap_full),
    .snap_push_o  (snap_push),
    .snap_count_o (f_count),
    .snap_sx_o    (f_sx),
    .snap_sy_o    (f_sy),
    .snap_sxx_o   (f_sxx),
    .snap_sxy_o   (f_sxy),
    .snap_ovf_o   (f_ovf)
  );

  // Pack and unpack the closed-set beat
  assign snap_wdata = {f_count, f_sx, f_sy, f_sxx, f_sxy, f_ovf};
  assign {b_count, b_sx, b_sy, b_sxx, b_sxy, b_ovf} = snap_rdata;

  lss_fifo #(
    .WIDTH (SnapW),
    .DEPTH (lss_pkg::SetQueueDepth)
  ) u_set_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .wdata_i (snap_wdata),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .rdata_o (snap_rdata),
    .empty_o (snap_empty)
  );

  lss_back #(
    .MAX_POINTS    (MAX_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_empty_i (snap_empty),
    .snap_pop_o   (snap_pop),
    .snap_count_i (b_count),
    .snap_sx_i    (b_sx),
    .snap_sy_i    (b_sy),
    .snap_sxx_i   (b_sxx),
    .snap_sxy_i   (b_sxy),
    .snap_ovf_i   (b_ovf),
    .pop_i        (pop),
    .empty_o      (empty),
    .slope_o      (slope_o),
    .no_slope_o   (no_slope_o),
    .overflowed_o (overflowed_o)
  );

endmodule

`default_nettype wire
